@@ hw/rtl/ffa_pkg.sv @@
// ---------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit allocator
// Sequencer states, memory request bundle and result bundle.
// ---------------------------------------------------------------------------
package ffa_pkg;

  localparam int ADDR_W  = 16;
  localparam int SIZE_W  = 17;
  localparam int BYTES_W = 19;
  localparam int CMP_W   = 18;
  localparam int STEP_W  = 18;
  localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(2 * 65536 + 8);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE_RD,
    ST_A_LINK,
    ST_A_EXAM,
    ST_A_CARVE,
    ST_A_RESUME,
    ST_I_WALK,
    ST_I_UPPER,
    ST_I_UMERGE,
    ST_I_LOWER_RD,
    ST_I_LOWER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              size_we;
    logic [ADDR_W-1:0] size_addr;
    logic [SIZE_W-1:0] size_wdata;
    logic              next_we;
    logic [ADDR_W-1:0] next_addr;
    logic [ADDR_W-1:0] next_wdata;
  } mem_req_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] granted_unit;
    logic              page_used;
  } result_t;

endpackage

@@ hw/rtl/ffa_heap_mem.sv @@
// ---------------------------------------------------------------------------
// ffa_heap_mem: block header store
// Link and size memories, one write port each, shared registered read.
// ---------------------------------------------------------------------------
module ffa_heap_mem #(
  parameter int HEAP_UNITS = 65536
) (
  input  logic                       clk,
  input  ffa_pkg::mem_req_t          req,
  output logic [ffa_pkg::ADDR_W-1:0] rd_next,
  output logic [ffa_pkg::SIZE_W-1:0] rd_size
);

  // Slots beyond the 16-bit address space are never reached. The slot is the
  // low address bits, so the heap size is a power of two.
  localparam int DEPTH = (HEAP_UNITS < 65536) ? HEAP_UNITS : 65536;
  localparam int AW    = $clog2(DEPTH);

  logic [ffa_pkg::ADDR_W-1:0] next_mem [DEPTH];
  logic [ffa_pkg::SIZE_W-1:0] size_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_addr[AW-1:0]] <= req.next_wdata;
    end
    if (req.size_we) begin
      size_mem[req.size_addr[AW-1:0]] <= req.size_wdata;
    end
    if (req.rd_en) begin
      rd_next <= next_mem[req.rd_addr[AW-1:0]];
      rd_size <= size_mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

@@ hw/rtl/ffa_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Walks the free list one header per read and rewrites headers in place.
// ---------------------------------------------------------------------------
module ffa_ctrl #(
  parameter int UNIT_BYTES = 8,
  parameter int PAGE_UNITS = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [ffa_pkg::BYTES_W-1:0] request_bytes,
  input  logic [ffa_pkg::ADDR_W-1:0]  block_unit,
  input  logic [ffa_pkg::ADDR_W-1:0]  page_unit,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ffa_pkg::result_t            res,
  output ffa_pkg::mem_req_t           mem_req,
  input  logic [ffa_pkg::ADDR_W-1:0]  rd_next_mem,
  input  logic [ffa_pkg::SIZE_W-1:0]  rd_size_mem
);

  localparam int AW     = ffa_pkg::ADDR_W;
  localparam int SW     = ffa_pkg::SIZE_W;
  localparam int CW     = ffa_pkg::CMP_W;
  localparam int TW     = ffa_pkg::STEP_W;
  localparam int UB_SH  = $clog2(UNIT_BYTES);
  localparam int NEED_W = ffa_pkg::BYTES_W - UB_SH + 1;

  ffa_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]     p_r, p_nxt, q_r, q_nxt, prev_r, prev_nxt;
  logic [AW-1:0]     rover_r, rover_nxt, sent_r, sent_nxt;
  logic [AW-1:0]     bp_r, bp_nxt, blink_r, blink_nxt, page_r, page_nxt;
  logic [SW-1:0]     bsz_r, bsz_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [TW-1:0]     astep_r, astep_nxt, istep_r, istep_nxt;
  logic              grown_r, grown_nxt, from_alloc_r, from_alloc_nxt;
  logic              rd_zero_r, rd_zero_nxt;
  ffa_pkg::result_t  res_r, res_nxt;

  logic [AW-1:0]     rd_next;
  logic [SW-1:0]     rd_size;
  logic [CW-1:0]     need_ext, sz_ext;
  logic [ffa_pkg::BYTES_W:0] bytes_sum;
  logic [NEED_W-1:0] need_calc;
  logic [TW-1:0]     astep_inc, istep_inc;
  logic              a_over, a_fit, a_exact, a_wrap, a_grow_ok;
  logic              i_brk, i_over, up_merge, lo_merge;
  logic [SW-1:0]     sz_left;
  logic [AW-1:0]     bp_in;
  logic              start;

  // The sentinel has size zero and its link lives in a register.
  assign rd_next = rd_zero_r ? sent_r : rd_next_mem;
  assign rd_size = rd_zero_r ? '0 : rd_size_mem;

  assign bytes_sum = {1'b0, request_bytes} + (ffa_pkg::BYTES_W + 1)'(UNIT_BYTES - 1);
  assign need_calc = NEED_W'(bytes_sum >> UB_SH) + NEED_W'(1);
  assign need_ext  = CW'(need_r);
  assign sz_ext    = CW'(rd_size);

  assign astep_inc = astep_r + TW'(1);
  assign istep_inc = istep_r + TW'(1);
  assign a_over    = astep_inc > ffa_pkg::STEP_LIMIT;
  assign i_over    = istep_inc > ffa_pkg::STEP_LIMIT;
  assign a_fit     = sz_ext >= need_ext;
  assign a_exact   = sz_ext == need_ext;
  assign a_wrap    = p_r == rover_r;
  assign a_grow_ok = !grown_r && (need_ext <= CW'(PAGE_UNITS)) && (page_r != '0);
  assign sz_left   = rd_size - SW'(need_r);

  // Insertion point: between p and its successor, or at the wrap of the ring.
  assign i_brk = ((bp_r > p_r) && (bp_r < rd_next)) ||
                 ((p_r >= rd_next) && ((bp_r > p_r) || (bp_r < rd_next)));
  assign up_merge = (CW'(bp_r) + CW'(bsz_r)) == CW'(q_r);
  assign lo_merge = (CW'(p_r) + CW'(rd_size)) == CW'(bp_r);

  assign bp_in = block_unit - AW'(1);
  assign start = in_valid && in_ready;

  assign in_ready  = state_r == ffa_pkg::ST_IDLE;
  assign res_valid = state_r == ffa_pkg::ST_DONE;
  assign res       = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffa_pkg::ST_IDLE: begin
        if (start) begin
          if (req_type == ffa_pkg::REQ_ALLOC) begin
            state_nxt = ffa_pkg::ST_A_LINK;
          end else if (bp_in == '0) begin
            state_nxt = ffa_pkg::ST_DONE;
          end else begin
            state_nxt = ffa_pkg::ST_FREE_RD;
          end
        end
      end
      ffa_pkg::ST_FREE_RD:  state_nxt = ffa_pkg::ST_I_WALK;
      ffa_pkg::ST_A_LINK:   state_nxt = ffa_pkg::ST_A_EXAM;
      ffa_pkg::ST_A_EXAM: begin
        if (a_over) begin
          state_nxt = ffa_pkg::ST_DONE;
        end else if (a_fit) begin
          state_nxt = a_exact ? ffa_pkg::ST_DONE : ffa_pkg::ST_A_CARVE;
        end else if (a_wrap) begin
          state_nxt = a_grow_ok ? ffa_pkg::ST_I_WALK : ffa_pkg::ST_DONE;
        end
      end
      ffa_pkg::ST_A_CARVE:  state_nxt = ffa_pkg::ST_DONE;
      ffa_pkg::ST_A_RESUME: state_nxt = ffa_pkg::ST_A_LINK;
      ffa_pkg::ST_I_WALK: begin
        if (i_brk) begin
          state_nxt = ffa_pkg::ST_I_UPPER;
        end else if (i_over) begin
          state_nxt = ffa_pkg::ST_DONE;
        end
      end
      ffa_pkg::ST_I_UPPER: begin
        state_nxt = up_merge ? ffa_pkg::ST_I_UMERGE : ffa_pkg::ST_I_LOWER_RD;
      end
      ffa_pkg::ST_I_UMERGE:   state_nxt = ffa_pkg::ST_I_LOWER_RD;
      ffa_pkg::ST_I_LOWER_RD: state_nxt = ffa_pkg::ST_I_LOWER;
      ffa_pkg::ST_I_LOWER: begin
        state_nxt = from_alloc_r ? ffa_pkg::ST_A_RESUME : ffa_pkg::ST_DONE;
      end
      ffa_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = ffa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    p_nxt          = p_r;
    q_nxt          = q_r;
    prev_nxt       = prev_r;
    rover_nxt      = rover_r;
    sent_nxt       = sent_r;
    bp_nxt         = bp_r;
    blink_nxt      = blink_r;
    page_nxt       = page_r;
    bsz_nxt        = bsz_r;
    need_nxt       = need_r;
    astep_nxt      = astep_r;
    istep_nxt      = istep_r;
    grown_nxt      = grown_r;
    from_alloc_nxt = from_alloc_r;
    rd_zero_nxt    = rd_zero_r;
    res_nxt        = res_r;
    mem_req        = '0;

    case (state_r)
      ffa_pkg::ST_IDLE: begin
        if (start) begin
          res_nxt = '0;
          if (req_type == ffa_pkg::REQ_ALLOC) begin
            need_nxt        = need_calc;
            page_nxt        = page_unit;
            prev_nxt        = rover_r;
            astep_nxt       = '0;
            grown_nxt       = 1'b0;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rover_r;
            rd_zero_nxt     = rover_r == '0;
          end else begin
            bp_nxt          = bp_in;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = bp_in;
            rd_zero_nxt     = 1'b0;
          end
        end
      end
      ffa_pkg::ST_FREE_RD: begin
        bsz_nxt         = rd_size;
        from_alloc_nxt  = 1'b0;
        p_nxt           = rover_r;
        istep_nxt       = '0;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = rover_r;
        rd_zero_nxt     = rover_r == '0;
      end
      ffa_pkg::ST_A_LINK: begin
        p_nxt           = rd_next;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = rd_next;
        rd_zero_nxt     = rd_next == '0;
      end
      ffa_pkg::ST_A_EXAM: begin
        astep_nxt = astep_inc;
        if (a_over) begin
          res_nxt.status    = 1'b1;
          res_nxt.page_used = grown_r;
        end else if (a_fit) begin
          rover_nxt         = prev_r;
          res_nxt.page_used = grown_r;
          if (a_exact) begin
            res_nxt.granted_unit = p_r + AW'(1);
            if (prev_r == '0) begin
              sent_nxt = rd_next;
            end else begin
              mem_req.next_we    = 1'b1;
              mem_req.next_addr  = prev_r;
              mem_req.next_wdata = rd_next;
            end
          end else begin
            // Shrink the block and hand out its tail.
            mem_req.size_we    = p_r != '0;
            mem_req.size_addr  = p_r;
            mem_req.size_wdata = sz_left;
            p_nxt              = p_r + AW'(sz_left);
          end
        end else if (a_wrap) begin
          if (a_grow_ok) begin
            bp_nxt          = page_r;
            bsz_nxt         = SW'(PAGE_UNITS);
            from_alloc_nxt  = 1'b1;
            p_nxt           = rover_r;
            istep_nxt       = '0;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rover_r;
            rd_zero_nxt     = rover_r == '0;
          end else begin
            res_nxt.status    = 1'b1;
            res_nxt.page_used = grown_r;
          end
        end else begin
          prev_nxt        = p_r;
          p_nxt           = rd_next;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_next;
          rd_zero_nxt     = rd_next == '0;
        end
      end
      ffa_pkg::ST_A_CARVE: begin
        mem_req.size_we      = p_r != '0;
        mem_req.size_addr    = p_r;
        mem_req.size_wdata   = SW'(need_r);
        res_nxt.granted_unit = p_r + AW'(1);
      end
      ffa_pkg::ST_A_RESUME: begin
        prev_nxt        = rover_r;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = rover_r;
        rd_zero_nxt     = rover_r == '0;
      end
      ffa_pkg::ST_I_WALK: begin
        if (i_brk) begin
          q_nxt              = rd_next;
          mem_req.size_we    = bp_r != '0;
          mem_req.size_addr  = bp_r;
          mem_req.size_wdata = bsz_r;
        end else if (i_over) begin
          res_nxt.status    = from_alloc_r;
          res_nxt.page_used = 1'b0;
        end else begin
          istep_nxt       = istep_inc;
          p_nxt           = rd_next;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_next;
          rd_zero_nxt     = rd_next == '0;
        end
      end
      ffa_pkg::ST_I_UPPER: begin
        if (up_merge) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = q_r;
          rd_zero_nxt     = q_r == '0;
        end else begin
          mem_req.next_we    = 1'b1;
          mem_req.next_addr  = bp_r;
          mem_req.next_wdata = q_r;
          blink_nxt          = q_r;
        end
      end
      ffa_pkg::ST_I_UMERGE: begin
        bsz_nxt            = bsz_r + rd_size;
        mem_req.size_we    = bp_r != '0;
        mem_req.size_addr  = bp_r;
        mem_req.size_wdata = bsz_r + rd_size;
        mem_req.next_we    = 1'b1;
        mem_req.next_addr  = bp_r;
        mem_req.next_wdata = rd_next;
        blink_nxt          = rd_next;
      end
      ffa_pkg::ST_I_LOWER_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = p_r;
        rd_zero_nxt     = p_r == '0;
      end
      ffa_pkg::ST_I_LOWER: begin
        rover_nxt = p_r;
        if (lo_merge) begin
          mem_req.size_we    = p_r != '0;
          mem_req.size_addr  = p_r;
          mem_req.size_wdata = rd_size + bsz_r;
        end
        if (p_r == '0) begin
          sent_nxt = lo_merge ? blink_r : bp_r;
        end else begin
          mem_req.next_we    = 1'b1;
          mem_req.next_addr  = p_r;
          mem_req.next_wdata = lo_merge ? blink_r : bp_r;
        end
        if (from_alloc_r) begin
          grown_nxt = 1'b1;
        end
      end
      ffa_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::ST_IDLE;
      rover_r <= '0;
      sent_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rover_r <= rover_nxt;
      sent_r  <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    prev_r       <= prev_nxt;
    bp_r         <= bp_nxt;
    blink_r      <= blink_nxt;
    page_r       <= page_nxt;
    bsz_r        <= bsz_nxt;
    need_r       <= need_nxt;
    astep_r      <= astep_nxt;
    istep_r      <= istep_nxt;
    grown_r      <= grown_nxt;
    from_alloc_r <= from_alloc_nxt;
    rd_zero_r    <= rd_zero_nxt;
    res_r        <= res_nxt;
  end

endmodule

@@ hw/rtl/first_fit_free_list_allocator.sv @@
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator: address-ordered first-fit heap allocator
// An allocation examines one block per header read, plus a carve state on a split; a
// free walks the list one header per read, then writes the upper side (merging upward
// if it can) and reads and writes the lower side; a free of the sentinel goes straight
// to the result. Taking a page in runs the same insertion as a free. One request is in
// flight at a time: the next beat is taken in the cycle after the result moves to the
// output register. Reset sets the rover and the sentinel link to unit 0; the header
// memories are not cleared and hold nothing meaningful until written.
// ---------------------------------------------------------------------------
module first_fit_free_list_allocator #(
  parameter int HEAP_UNITS = 65536,
  parameter int UNIT_BYTES = 8,
  parameter int PAGE_UNITS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // request_bytes [18:0], block_unit [34:19], page_unit [50:35], zero fill
  input  logic [55:0] in_tdata,
  // req_type [0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // granted_unit [15:0], page_used [16], zero fill
  output logic [23:0] out_tdata,
  // status [0]
  output logic        out_tuser
);

  ffa_pkg::mem_req_t                mem_req;
  logic [ffa_pkg::ADDR_W-1:0]       rd_next;
  logic [ffa_pkg::SIZE_W-1:0]       rd_size;
  ffa_pkg::result_t                 res;
  logic                             res_valid;
  logic                             res_ready;
  logic                             out_valid_r, out_valid_nxt;
  ffa_pkg::result_t                 out_r, out_nxt;

  // The header store: one link and one size per unit slot.
  ffa_heap_mem #(
    .HEAP_UNITS(HEAP_UNITS)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_next (rd_next),
    .rd_size (rd_size)
  );

  // The sequencer performs one request at a time, walking the list through
  // the memory's single read port.
  ffa_ctrl #(
    .UNIT_BYTES(UNIT_BYTES),
    .PAGE_UNITS(PAGE_UNITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .req_type      (in_tuser),
    .request_bytes (in_tdata[18:0]),
    .block_unit    (in_tdata[34:19]),
    .page_unit     (in_tdata[50:35]),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_req       (mem_req),
    .rd_next_mem   (rd_next),
    .rd_size_mem   (rd_size)
  );

  // Output register: a finished result waits here, so the sequencer can take
  // the next request while the previous beat is still unaccepted.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_r.page_used, out_r.granted_unit};
  assign out_tuser  = out_r.status;

endmodule

@@ bench/tb_first_fit_free_list_allocator.sv @@
// ---------------------------------------------------------------------------
// tb_first_fit_free_list_allocator: self-checking bench for the allocator
// A request list is built up front, and a heap model predicts each response
// as the list is built. The model also decides which fresh pages are handed
// in and which live blocks are freed, so that no walk ever meets a header
// that was never written. A driver and a monitor run the stream ports with
// random gaps and stalls, and every response beat is compared field by field.
// ---------------------------------------------------------------------------
module tb_first_fit_free_list_allocator;

  localparam int UNIT_B     = 8;
  localparam int PAGE_U     = 512;
  localparam int NUM_PAGES  = 128;
  localparam int RAND_ITEMS = 750;

  // One request as it goes onto the input stream.
  typedef struct {
    logic              kind;
    logic [18:0]       bytes;
    logic [15:0]       blk;
    logic [15:0]       page;
    bit                drain;
  } heap_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;

  first_fit_free_list_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // -------------------------------------------------------------------------
  // Heap model. Headers are indexed by unit address directly, since the heap
  // spans the whole 16-bit unit space. Unit 0 is the sentinel: its size reads
  // as zero and its link lives in a register of its own.
  // -------------------------------------------------------------------------
  logic [15:0] hdr_link [65536];
  logic [16:0] hdr_size [65536];
  logic [15:0] rover_m;
  logic [15:0] sentinel_link;
  localparam int WALK_LIMIT = 2 * 65536 + 8;

  function automatic logic [15:0] link_of(input logic [15:0] a);
    return (a == 16'd0) ? sentinel_link : hdr_link[a];
  endfunction

  function automatic void put_link(input logic [15:0] a, input logic [15:0] v);
    if (a == 16'd0) sentinel_link = v;
    else hdr_link[a] = v;
  endfunction

  function automatic logic [16:0] size_of(input logic [15:0] a);
    return (a == 16'd0) ? 17'd0 : hdr_size[a];
  endfunction

  function automatic void put_size(input logic [15:0] a, input logic [16:0] v);
    if (a != 16'd0) hdr_size[a] = v;
  endfunction

  // Address-ordered insertion with merging on both sides; 0 if the walk ran away.
  function automatic bit link_in_block(input logic [15:0] bp, input logic [16:0] sz);
    logic [15:0] p;
    logic [15:0] q;
    int          steps;
    p = rover_m;
    steps = 0;
    forever begin
      q = link_of(p);
      if (bp > p && bp < q) break;
      if (p >= q && (bp > p || bp < q)) break;
      steps++;
      if (steps > WALK_LIMIT) return 1'b0;
      p = q;
    end
    put_size(bp, sz);
    q = link_of(p);
    if (int'(bp) + int'(size_of(bp)) == int'(q)) begin
      put_size(bp, size_of(bp) + size_of(q));
      put_link(bp, link_of(q));
    end else begin
      put_link(bp, q);
    end
    if (int'(p) + int'(size_of(p)) == int'(bp)) begin
      put_size(p, size_of(p) + size_of(bp));
      put_link(p, link_of(bp));
    end else begin
      put_link(p, bp);
    end
    rover_m = p;
    return 1'b1;
  endfunction

  // Works out the response to one request and updates the heap model.
  function automatic ffa_pkg::result_t heap_response(input heap_req_t r);
    ffa_pkg::result_t res;
    logic [15:0]      bp;
    logic [15:0]      prev;
    logic [15:0]      p;
    int               need;
    int               sz;
    int               steps;
    bit               grown;
    res = '0;
    if (r.kind == ffa_pkg::REQ_FREE) begin
      bp = r.blk - 16'd1;
      if (bp != 16'd0) void'(link_in_block(bp, size_of(bp)));
      return res;
    end
    need  = (int'(r.bytes) + UNIT_B - 1) / UNIT_B + 1;
    prev  = rover_m;
    p     = link_of(prev);
    grown = 1'b0;
    steps = 0;
    forever begin
      steps++;
      if (steps > WALK_LIMIT) break;
      sz = int'(size_of(p));
      if (sz >= need) begin
        if (sz == need) begin
          put_link(prev, link_of(p));
        end else begin
          sz = sz - need;
          put_size(p, 17'(sz));
          p = p + 16'(sz);
          put_size(p, 17'(need));
        end
        rover_m          = prev;
        res.granted_unit = p + 16'd1;
        res.page_used    = grown;
        return res;
      end
      if (p == rover_m) begin
        if (grown || need > PAGE_U || r.page == 16'd0) break;
        if (!link_in_block(r.page, 17'(PAGE_U))) break;
        grown = 1'b1;
        p = rover_m;
      end
      prev = p;
      p = link_of(p);
    end
    res.status    = 1'b1;
    res.page_used = grown;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Request generation. Fresh pages are whole 512-unit slots that the heap
  // has never owned; live blocks are the granted areas not yet freed.
  // -------------------------------------------------------------------------
  heap_req_t        pending_reqs[$];
  ffa_pkg::result_t awaited_resp[$];
  logic [15:0]      live_blocks[$];
  bit               page_taken[NUM_PAGES];
  int               total_reqs;
  bit               gen_done;

  function automatic logic [15:0] pick_fresh_page(input int want);
    int k;
    int tries;
    if (want >= 0 && !page_taken[want]) return 16'(1 + PAGE_U * want);
    for (tries = 0; tries < 64; tries++) begin
      k = $urandom_range(0, NUM_PAGES - 1);
      if (!page_taken[k]) return 16'(1 + PAGE_U * k);
    end
    return 16'd0;
  endfunction

  task automatic add_alloc(input int bytes, input bit no_page, input int want_pg,
                           input bit drain);
    heap_req_t        r;
    ffa_pkg::result_t res;
    r.kind  = ffa_pkg::REQ_ALLOC;
    r.bytes = 19'(bytes);
    r.blk   = 16'($urandom);
    r.page  = no_page ? 16'd0 : pick_fresh_page(want_pg);
    r.drain = drain;
    res = heap_response(r);
    if (res.page_used) page_taken[(int'(r.page) - 1) / PAGE_U] = 1'b1;
    // A page that the search never reached may carry any value at all.
    else if (res.status == 1'b0 || (bytes + UNIT_B - 1) / UNIT_B + 1 > PAGE_U)
      r.page = 16'($urandom);
    if (res.status == 1'b0) live_blocks.push_back(res.granted_unit);
    pending_reqs.push_back(r);
    awaited_resp.push_back(res);
  endtask

  task automatic add_free(input int idx, input logic [15:0] raw_blk, input bit drain);
    heap_req_t r;
    r.kind  = ffa_pkg::REQ_FREE;
    r.bytes = 19'($urandom);
    r.page  = 16'($urandom);
    r.drain = drain;
    if (idx >= 0) begin
      r.blk = live_blocks[idx];
      live_blocks.delete(idx);
    end else begin
      r.blk = raw_blk;
    end
    pending_reqs.push_back(r);
    awaited_resp.push_back(heap_response(r));
  endtask

  function automatic int random_bytes();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(0, 120);
    if (sel < 95) return $urandom_range(121, (PAGE_U - 1) * UNIT_B);
    return $urandom_range(0, 19'h7FFFF);
  endfunction

  initial begin
    int i;
    rst_n         = 1'b0;
    gen_done      = 1'b0;
    rover_m       = 16'd0;
    sentinel_link = 16'd0;
    foreach (page_taken[k]) page_taken[k] = 1'b0;

    // Directed opening: the zero page with an empty heap, the first page at
    // the very top of the address space, the smallest and exact-page sizes,
    // requests too big for a page, and a free of the sentinel.
    add_alloc(100, 1'b1, -1, 1'b0);
    add_alloc(0, 1'b0, NUM_PAGES - 1, 1'b0);
    add_alloc(1, 1'b0, -1, 1'b0);
    add_alloc(8, 1'b0, -1, 1'b0);
    add_alloc(9, 1'b0, -1, 1'b0);
    add_alloc((PAGE_U - 1) * UNIT_B, 1'b0, 0, 1'b0);
    add_alloc((PAGE_U - 1) * UNIT_B + 1, 1'b0, -1, 1'b0);
    add_alloc(19'h7FFFF, 1'b0, -1, 1'b0);
    add_free(-1, 16'd1, 1'b0);
    add_free(1, 16'd0, 1'b0);
    add_free(0, 16'd0, 1'b0);
    add_alloc(0, 1'b0, -1, 1'b0);
    add_free(live_blocks.size() - 1, 16'd0, 1'b0);
    add_alloc(9, 1'b0, -1, 1'b0);
    while (live_blocks.size() > 0) add_free(0, 16'd0, 1'b0);
    add_alloc(4000, 1'b0, -1, 1'b0);

    // Random part: a mixture of allocations and frees of live blocks. One
    // request in the middle waits until every earlier response has come.
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (live_blocks.size() == 0 ||
          (live_blocks.size() < 60 && $urandom_range(0, 99) < 55))
        add_alloc(random_bytes(), 1'b0, -1, i == RAND_ITEMS / 2);
      else
        add_free($urandom_range(0, live_blocks.size() - 1), 16'd0,
                 i == RAND_ITEMS / 2);
    end
    total_reqs = pending_reqs.size();
    gen_done   = 1'b1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // -------------------------------------------------------------------------
  // Driver: one decision per edge, taken whenever the current beat has gone
  // or none is on offer.
  // -------------------------------------------------------------------------
  int reqs_accepted;
  int resps_seen;
  int send_gap;

  always @(posedge clk) begin
    int        accepted_now;
    int        r;
    heap_req_t nx;
    if (!rst_n) begin
      in_tvalid     <= 1'b0;
      in_tdata      <= '0;
      in_tuser      <= 1'b0;
      reqs_accepted <= 0;
      send_gap      <= 0;
    end else begin
      accepted_now = reqs_accepted;
      if (in_tvalid && in_tready) accepted_now++;
      reqs_accepted <= accepted_now;
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain && resps_seen != accepted_now)) begin
          in_tvalid <= 1'b0;
        end else begin
          nx = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nx.kind;
          in_tdata  <= {5'd0, nx.page, nx.blk, nx.bytes};
          // Calm stretches alternate with stretches of short and long gaps.
          r = $urandom_range(0, 99);
          if (((accepted_now / 100) % 3) == 0 || r < 60) send_gap <= 0;
          else if (r < 95) send_gap <= $urandom_range(1, 3);
          else send_gap <= $urandom_range(10, 60);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // offering requests so that the block backs up into its input.
  // -------------------------------------------------------------------------
  int  stall_left;
  bit  long_hold_done;
  int  rx_cycles;

  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_tready     <= 1'b0;
      stall_left     <= 0;
      long_hold_done <= 1'b0;
      rx_cycles      <= 0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!long_hold_done && reqs_accepted >= 200) begin
        long_hold_done <= 1'b1;
        out_tready     <= 1'b0;
        stall_left     <= 3000;
      end else begin
        r = $urandom_range(0, 99);
        if (((rx_cycles / 4096) % 3) == 1 || r < 70) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall_left <= (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor and checking.
  // -------------------------------------------------------------------------
  int err_cnt = 0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    ffa_pkg::result_t want;
    if (!rst_n) begin
      resps_seen <= 0;
    end else if (out_tvalid && out_tready) begin
      resps_seen <= resps_seen + 1;
      if (awaited_resp.size() == 0) begin
        report("response beat with no request waiting for one");
      end else begin
        want = awaited_resp.pop_front();
        if (out_tuser !== want.status)
          report($sformatf("response %0d status %b, want %b",
                           resps_seen, out_tuser, want.status));
        if (out_tdata[15:0] !== want.granted_unit)
          report($sformatf("response %0d granted_unit %0d, want %0d",
                           resps_seen, out_tdata[15:0], want.granted_unit));
        if (out_tdata[16] !== want.page_used)
          report($sformatf("response %0d page_used %b, want %b",
                           resps_seen, out_tdata[16], want.page_used));
      end
    end
  end

  // End of run: every request sent, every response in, then a short settle.
  initial begin
    wait (gen_done && rst_n);
    while (pending_reqs.size() != 0 || in_tvalid) @(posedge clk);
    while (resps_seen < total_reqs) @(posedge clk);
    repeat (200) @(posedge clk);
    if (awaited_resp.size() != 0) report("responses still outstanding at the end");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #(12 * 4000000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ first_fit_free_list_allocator.f @@
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_heap_mem.sv
hw/rtl/ffa_ctrl.sv
hw/rtl/first_fit_free_list_allocator.sv
bench/tb_first_fit_free_list_allocator.sv
